FILE: design/hbrp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbrp_pkg
// Types and constants shared by the byte-range set parser.
// ----------------------------------------------------------------------------
package hbrp_pkg;

    localparam int OFFSET_W  = 63;
    localparam int STATUS_W  = 3;
    localparam int COUNT_W   = 7;
    localparam int CHAR_W    = 8;
    localparam int OUT_TDATA_W = 136;

    localparam logic [COUNT_W-1:0] MAX_RANGES_RST = 7'd12;

    localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK          = 3'd0,
        STATUS_BAD_CHAR    = 3'd1,
        STATUS_LAST_BEFORE = 3'd2,
        STATUS_ZERO_SUFFIX = 3'd3,
        STATUS_TOO_MANY    = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        PH_START,
        PH_FIRST,
        PH_AFTER_DASH,
        PH_LAST,
        PH_SUFFIX_DASH,
        PH_SUFFIX,
        PH_HALTED
    } phase_t;

endpackage

FILE: design/http_byte_range_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_byte_range_parser_core
// Parses an HTTP byte-range set one character per item into range records.
// ----------------------------------------------------------------------------
// Takes the text after "bytes=" one character per item and emits one result
// item for each completed spec ("a-b" as offset and count, "a-" open ended,
// "-n" as suffix), an error item that ends the run, or an empty item closing
// a run that ends without a record. Sustained rate is one character per
// cycle; a held result stalls only a character with a result of its own.
// The depth of the single stage is set by the saturating decimal shift-add
// and the last-minus-first subtract on NUMBER_BITS wide values. The user
// must write max_ranges on the cfg channel only while the parser is idle;
// the block itself does not enforce this.
module http_byte_range_parser_core #(
    parameter int NUMBER_BITS = 63
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // cfg_data: max_ranges
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [hbrp_pkg::COUNT_W-1:0]    cfg_data,
    // s_axis_tdata: char_in[7:0]
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [hbrp_pkg::CHAR_W-1:0]     s_axis_tdata,
    input  logic                            s_axis_tlast,
    // m_axis_tdata: range_valid[0], from_end[1], start_offset[64:2],
    // byte_count[127:65], open_ended[128], status[131:129], zero pad
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [hbrp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tlast
);
    import hbrp_pkg::*;

    localparam int NB    = NUMBER_BITS;
    localparam int ACC_W = NB + 4;
    localparam logic [NB-1:0] NUM_MAX = {NB{1'b1}};

    // configuration
    logic [COUNT_W-1:0] max_ranges_reg;

    // input register
    logic              in_valid_reg;
    logic [CHAR_W-1:0] char_reg;
    logic              eot_reg;

    // run state
    phase_t             ph_reg, ph_next;
    logic [NB-1:0]      fv_reg, fv_next;
    logic [NB-1:0]      sv_reg, sv_next;
    logic [COUNT_W-1:0] rs_reg, rs_next;
    logic               disc_reg, disc_next;

    // result register
    logic                out_valid_reg;
    logic                out_range_valid_reg;
    logic                out_from_end_reg;
    logic [OFFSET_W-1:0] out_start_reg;
    logic [OFFSET_W-1:0] out_count_reg;
    logic                out_open_reg;
    status_t             out_status_reg;
    logic                out_done_reg;

    logic consume;
    logic res_has;

    // character decode
    logic          is_digit;
    logic [3:0]    digit;
    logic          is_dash;
    logic          is_comma;

    // shared saturating accumulator
    logic [NB-1:0]    acc_in;
    logic [ACC_W-1:0] acc_sum;
    logic [NB-1:0]    acc_out;

    // character stage
    phase_t        ph_a;
    logic [NB-1:0] fv_a;
    logic [NB-1:0] sv_a;
    logic          disc_a;
    logic          char_cmp;
    logic          char_bad;

    // spec completion
    logic          comp_fail;
    status_t       comp_status;
    logic          comp_fe;
    logic [NB-1:0] comp_start;
    logic [NB-1:0] comp_count;
    logic          comp_open;
    logic [NB-1:0] diff;
    logic          too_many;

    // end of text
    logic eot_cmp;
    logic eot_bad;
    logic eot_empty;
    logic use_comp;
    logic bad;

    assign is_digit = char_reg inside {[CH_ZERO:CH_NINE]};
    assign digit    = is_digit ? 4'(char_reg - CH_ZERO) : 4'd0;
    assign is_dash  = (char_reg == CH_DASH);
    assign is_comma = (char_reg == CH_COMMA);

    // v*10 + d, saturating at the field maximum
    assign acc_in  = (ph_reg == PH_FIRST) ? fv_reg : sv_reg;
    assign acc_sum = {1'b0, acc_in, 3'b000} + {3'b000, acc_in, 1'b0} + ACC_W'(digit);
    assign acc_out = (acc_sum[ACC_W-1:NB] != 4'd0) ? NUM_MAX : acc_sum[NB-1:0];

    always_comb
    begin
        ph_a     = ph_reg;
        fv_a     = fv_reg;
        sv_a     = sv_reg;
        disc_a   = disc_reg;
        char_cmp = 1'b0;
        char_bad = 1'b0;
        if (disc_reg)
        begin
            if (is_comma)
            begin
                disc_a = 1'b0;
                ph_a   = PH_START;
            end
        end
        else
        begin
            case (ph_reg)
                PH_START:
                begin
                    if (is_digit)
                    begin
                        fv_a = NB'(digit);
                        ph_a = PH_FIRST;
                    end
                    else if (is_dash)
                        ph_a = PH_SUFFIX_DASH;
                    else
                        char_bad = 1'b1;
                end
                PH_FIRST:
                begin
                    if (is_digit)
                        fv_a = acc_out;
                    else if (is_dash)
                        ph_a = PH_AFTER_DASH;
                    else
                        char_bad = 1'b1;
                end
                PH_AFTER_DASH:
                begin
                    if (is_digit)
                    begin
                        sv_a = NB'(digit);
                        ph_a = PH_LAST;
                    end
                    else if (is_comma)
                        char_cmp = 1'b1;
                    else
                        char_bad = 1'b1;
                end
                PH_SUFFIX_DASH:
                begin
                    if (is_digit)
                    begin
                        sv_a = NB'(digit);
                        ph_a = PH_SUFFIX;
                    end
                    else
                        char_bad = 1'b1;
                end
                PH_LAST, PH_SUFFIX:
                begin
                    if (is_digit)
                        sv_a = acc_out;
                    else
                        char_cmp = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // ph_a still names the open spec whenever a completion is taken
    assign diff     = sv_a - fv_a;
    assign too_many = (rs_reg >= max_ranges_reg);

    always_comb
    begin
        comp_fail   = 1'b0;
        comp_status = STATUS_OK;
        comp_fe     = 1'b0;
        comp_start  = '0;
        comp_count  = '0;
        comp_open   = 1'b0;
        case (ph_a)
            PH_AFTER_DASH:
            begin
                comp_start = fv_a;
                comp_open  = 1'b1;
            end
            PH_LAST:
            begin
                if (sv_a < fv_a)
                begin
                    comp_fail   = 1'b1;
                    comp_status = STATUS_LAST_BEFORE;
                end
                else
                begin
                    comp_start = fv_a;
                    comp_count = (diff == NUM_MAX) ? diff : diff + NB'(1);
                end
            end
            PH_SUFFIX:
            begin
                if (sv_a == '0)
                begin
                    comp_fail   = 1'b1;
                    comp_status = STATUS_ZERO_SUFFIX;
                end
                else
                begin
                    comp_fe    = 1'b1;
                    comp_count = sv_a;
                end
            end
            default:
            begin
            end
        endcase
        if (!comp_fail && too_many)
        begin
            comp_fail   = 1'b1;
            comp_status = STATUS_TOO_MANY;
        end
        if (comp_fail)
        begin
            comp_fe    = 1'b0;
            comp_start = '0;
            comp_count = '0;
            comp_open  = 1'b0;
        end
    end

    always_comb
    begin
        eot_cmp   = 1'b0;
        eot_bad   = 1'b0;
        eot_empty = 1'b0;
        if (eot_reg && !char_cmp && !char_bad)
        begin
            if (disc_a)
                eot_empty = 1'b1;
            else
            begin
                case (ph_a)
                    PH_START:                    eot_empty = 1'b1;
                    PH_FIRST, PH_SUFFIX_DASH:    eot_bad   = 1'b1;
                    PH_AFTER_DASH, PH_LAST, PH_SUFFIX:
                                                 eot_cmp   = 1'b1;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign use_comp = char_cmp || eot_cmp;
    assign bad      = char_bad || eot_bad;
    assign res_has  = use_comp || bad || eot_empty;

    // next run state
    always_comb
    begin
        ph_next   = ph_a;
        fv_next   = fv_a;
        sv_next   = sv_a;
        rs_next   = rs_reg;
        disc_next = disc_a;
        if (eot_reg)
        begin
            ph_next   = PH_START;
            fv_next   = '0;
            sv_next   = '0;
            rs_next   = '0;
            disc_next = 1'b0;
        end
        else if (char_bad || (char_cmp && comp_fail))
        begin
            ph_next   = PH_HALTED;
            disc_next = 1'b0;
        end
        else if (char_cmp)
        begin
            ph_next   = PH_START;
            rs_next   = rs_reg + COUNT_W'(1);
            disc_next = !is_comma;
        end
    end

    assign consume       = in_valid_reg && (!out_valid_reg || m_axis_tready || !res_has);
    assign s_axis_tready = !in_valid_reg || consume;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_ranges_reg <= MAX_RANGES_RST;
        else if (cfg_valid && cfg_ready)
            max_ranges_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tvalid && s_axis_tready)
            in_valid_reg <= 1'b1;
        else if (consume)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            char_reg <= s_axis_tdata;
            eot_reg  <= s_axis_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg   <= PH_START;
            fv_reg   <= '0;
            sv_reg   <= '0;
            rs_reg   <= '0;
            disc_reg <= 1'b0;
        end
        else if (consume)
        begin
            ph_reg   <= ph_next;
            fv_reg   <= fv_next;
            sv_reg   <= sv_next;
            rs_reg   <= rs_next;
            disc_reg <= disc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (consume && res_has)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (consume && res_has)
        begin
            out_range_valid_reg <= use_comp && !comp_fail;
            out_from_end_reg    <= use_comp && comp_fe;
            out_start_reg       <= use_comp ? OFFSET_W'(comp_start) : '0;
            out_count_reg       <= use_comp ? OFFSET_W'(comp_count) : '0;
            out_open_reg        <= use_comp && comp_open;
            out_status_reg      <= use_comp ? comp_status
                                 : (bad ? STATUS_BAD_CHAR : STATUS_OK);
            out_done_reg        <= eot_reg || bad || (use_comp && comp_fail);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_done_reg;
    assign m_axis_tdata  = {4'b0000, out_status_reg, out_open_reg, out_count_reg,
                            out_start_reg, out_from_end_reg, out_range_valid_reg};

    // a range record always carries ok status
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_range_valid_reg |-> out_status_reg == STATUS_OK)
        else $error("range record with error status");

    // any error item closes the run
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg != STATUS_OK |-> out_done_reg)
        else $error("error item without run_done");

    // end of text returns the run state to its start
    assert property (@(posedge clk) disable iff (!rst_n)
        consume && eot_reg |=> ph_reg == PH_START && rs_reg == '0 && !disc_reg)
        else $error("run state not cleared after end of text");

    // a halted run never skips toward a comma
    assert property (@(posedge clk) disable iff (!rst_n)
        ph_reg == PH_HALTED |-> !disc_reg)
        else $error("halted while discarding");

endmodule
